/* sv/vpm_pkg.sv */
package vpm_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int FRAC_BITS_DEF    = 16;
	localparam int TRIG_FRAC        = 30;
	localparam int ATAN_DEPTH       = 31;

	localparam logic [19:0] TURN_UNITS    = 20'd92160;
	localparam logic [19:0] QUARTER_UNITS = 20'd23040;
	localparam logic [47:0] UNIT_TO_RAD   = 48'd4797524517;
	localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;

	typedef logic signed [31:0] word_t;
	typedef logic signed [32:0] trig_t;
	typedef logic signed [71:0] wide_t;

	typedef enum logic [2:0] {
		REG_OUTPUT_MODE  = 3'd0,
		REG_PROJ_SCALE_X = 3'd1,
		REG_PROJ_SCALE_Y = 3'd2,
		REG_DEPTH_SCALE  = 3'd3,
		REG_DEPTH_OFFSET = 3'd4
	} cfg_reg_t;

	localparam word_t ATAN_TAB [0:ATAN_DEPTH-1] = '{
		32'sh3243F6A8, 32'sh1DAC6705, 32'sh0FADBAFC, 32'sh07F56EA6, 32'sh03FEAB76,
		32'sh01FFD55B, 32'sh00FFFAAA, 32'sh007FFF55, 32'sh003FFFEA, 32'sh001FFFFD,
		32'sh000FFFFF, 32'sh0007FFFF, 32'sh0003FFFF, 32'sh0001FFFF, 32'sh0000FFFF,
		32'sh00007FFF, 32'sh00003FFF, 32'sh00001FFF, 32'sh00000FFF, 32'sh000007FF,
		32'sh000003FF, 32'sh000001FF, 32'sh000000FF, 32'sh0000007F, 32'sh0000003F,
		32'sh0000001F, 32'sh0000000F, 32'sh00000008, 32'sh00000004, 32'sh00000002,
		32'sh00000001
	};

	// Q30 times Q30, rounded half up back to Q30
	function automatic trig_t mul30(input trig_t a, input trig_t b);
		logic signed [65:0] p;
		p = 66'(a) * 66'(b) + (66'sd1 <<< (TRIG_FRAC - 1));
		return p[62:30];
	endfunction

	function automatic word_t sat32(input wide_t v);
		if (v > 72'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -72'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

/* sv/euler_view_projection_matrix_core.sv */
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+---------------------------------------
// in       | sink      | in_valid / in_stall    | rot_x/y/z, pos_x/y/z
// out      | source    | out_valid / out_stall  | row_index, entry_c0..c3, last_row
// cfg      | sink      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// From input beat to row 0 the pipeline holds one stage per CORDIC step plus the stages around them.
// Each item leaves as four row beats from the final stage, paced by the output row
// sequencer; a new item is taken only while the final stage is empty or its last row leaves.
// All stages advance together; while the final stage still holds rows, everything holds
// and in_stall is high. arst_n clears valid bits and the row counter and loads the
// config registers with their reset values.
module euler_view_projection_matrix_core #(
	parameter int CORDIC_STEPS = vpm_pkg::CORDIC_STEPS_DEF,
	parameter int FRAC_BITS    = vpm_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [17:0]  rot_x,
	input  logic signed [17:0]  rot_y,
	input  logic signed [17:0]  rot_z,
	input  vpm_pkg::word_t      pos_x,
	input  vpm_pkg::word_t      pos_y,
	input  vpm_pkg::word_t      pos_z,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          row_index,
	output vpm_pkg::word_t      entry_c0,
	output vpm_pkg::word_t      entry_c1,
	output vpm_pkg::word_t      entry_c2,
	output vpm_pkg::word_t      entry_c3,
	output logic                last_row,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import vpm_pkg::*;

	localparam int NST  = CORDIC_STEPS + 8;
	localparam int DOWN = TRIG_FRAC - FRAC_BITS;

	// config registers
	logic  mode_q;
	word_t kx_q, ky_q, kz_q, koff_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
			kx_q   <= 32'sd65536;
			ky_q   <= 32'sd65536;
			kz_q   <= -32'sd65536;
			koff_q <= -32'sd131072;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_OUTPUT_MODE:  mode_q <= cfg_data[0];
				REG_PROJ_SCALE_X: kx_q   <= cfg_data;
				REG_PROJ_SCALE_Y: ky_q   <= cfg_data;
				REG_DEPTH_SCALE:  kz_q   <= cfg_data;
				REG_DEPTH_OFFSET: koff_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control: every stage moves on adv
	logic [NST-1:0] vld_q;
	logic [1:0]     row_q;
	logic           adv;
	logic           out_fire;

	assign out_valid = vld_q[NST-1];
	assign out_fire  = out_valid && !out_stall;
	assign adv       = !vld_q[NST-1] || (out_fire && (row_q == 2'd3));
	assign in_stall  = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			row_q <= 2'd0;
		end else begin
			if (adv) begin
				vld_q <= {vld_q[NST-2:0], in_valid};
			end
			if (out_fire) begin
				row_q <= row_q + 2'd1;
			end
		end
	end

	// stage 1: reduce angle to a turn, split quadrant and residual
	logic signed [17:0] rot_in [0:2];
	logic [1:0]  q_c [0:2];
	logic [14:0] f_c [0:2];

	assign rot_in[0] = rot_x;
	assign rot_in[1] = rot_y;
	assign rot_in[2] = rot_z;

	always_comb begin
		logic signed [19:0] aw;
		logic [19:0] r;
		for (int l = 0; l < 3; l++) begin
			aw = 20'(rot_in[l]);
			if (aw < -$signed(TURN_UNITS)) begin
				r = 20'(aw + $signed(TURN_UNITS) + $signed(TURN_UNITS));
			end else if (aw < 0) begin
				r = 20'(aw + $signed(TURN_UNITS));
			end else if (aw >= $signed(TURN_UNITS)) begin
				r = 20'(aw - $signed(TURN_UNITS));
			end else begin
				r = aw;
			end
			if (r >= 3 * QUARTER_UNITS) begin
				q_c[l] = 2'd3;
				f_c[l] = 15'(r - 3 * QUARTER_UNITS);
			end else if (r >= 2 * QUARTER_UNITS) begin
				q_c[l] = 2'd2;
				f_c[l] = 15'(r - 2 * QUARTER_UNITS);
			end else if (r >= QUARTER_UNITS) begin
				q_c[l] = 2'd1;
				f_c[l] = 15'(r - QUARTER_UNITS);
			end else begin
				q_c[l] = 2'd0;
				f_c[l] = 15'(r);
			end
		end
	end

	// pipeline registers
	logic [1:0]  q_s1 [0:2];
	logic [14:0] f_s1 [0:2];
	word_t       pos_s1 [0:2];
	word_t       x_s3 [0:CORDIC_STEPS][0:2];
	word_t       y_s3 [0:CORDIC_STEPS][0:2];
	word_t       z_s3 [0:CORDIC_STEPS][0:2];
	logic [1:0]  q_s3 [0:CORDIC_STEPS][0:2];
	word_t       pos_s3 [0:CORDIC_STEPS][0:2];
	trig_t       s_s4 [0:2];
	trig_t       c_s4 [0:2];
	word_t       pos_s4 [0:2];
	trig_t       sxsy_s5, cxsy_s5, cxsz_s5, cxcz_s5, sxsz_s5, sxcz_s5, sz_s5, cz_s5;
	trig_t       r00_s5, r01_s5, r02_s5, r12_s5, r22_s5;
	word_t       pos_s5 [0:2];
	trig_t       r_s6 [0:2][0:2];
	word_t       pos_s6 [0:2];
	logic signed [64:0] pr_s7 [0:2][0:2];
	trig_t       r_s7 [0:2][0:2];
	trig_t       r_s8 [0:2][0:2];
	word_t       t_s8 [0:2];
	word_t       e_s9 [0:3][0:3];

	// stage 2 (cordic index 0): residual to Q30 radians
	logic  [47:0] zp_c [0:2];
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			zp_c[l] = 48'(f_s1[l]) * UNIT_TO_RAD + 48'd32768;
		end
	end

	// quadrant fixup after the last step
	trig_t s_c [0:2];
	trig_t c_c [0:2];
	always_comb begin
		trig_t x, y;
		for (int l = 0; l < 3; l++) begin
			x = 33'(x_s3[CORDIC_STEPS][l]);
			y = 33'(y_s3[CORDIC_STEPS][l]);
			case (q_s3[CORDIC_STEPS][l])
				2'd0:    begin c_c[l] = x;  s_c[l] = y;  end
				2'd1:    begin c_c[l] = -y; s_c[l] = x;  end
				2'd2:    begin c_c[l] = -x; s_c[l] = -y; end
				default: begin c_c[l] = y;  s_c[l] = -x; end
			endcase
		end
	end

	// translation column: t = -R * pos, rounded and saturated
	word_t t_c [0:2];
	always_comb begin
		wide_t acc;
		for (int i = 0; i < 3; i++) begin
			acc = 72'(pr_s7[i][0]) + 72'(pr_s7[i][1]) + 72'(pr_s7[i][2]);
			acc = ((-acc) + (72'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
			t_c[i] = sat32(acc);
		end
	end

	// output entries for either mode
	word_t e_c [0:3][0:3];
	always_comb begin
		wide_t v;
		word_t k;
		for (int i = 0; i < 3; i++) begin
			case (i)
				0:       k = kx_q;
				1:       k = ky_q;
				default: k = kz_q;
			endcase
			for (int j = 0; j < 3; j++) begin
				if (mode_q) begin
					v = (72'(k) * 72'(r_s8[i][j]) + (72'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
				end else begin
					v = (72'(r_s8[i][j]) + (72'sd1 <<< (DOWN - 1))) >>> DOWN;
				end
				e_c[i][j] = sat32(v);
			end
			if (mode_q) begin
				v = 72'(k) * 72'(t_s8[i]);
				if (i == 2) begin
					v = v + (72'(koff_q) <<< FRAC_BITS);
				end
				v = (v + (72'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
				e_c[i][3] = sat32(v);
			end else begin
				e_c[i][3] = t_s8[i];
			end
		end
		for (int j = 0; j < 3; j++) begin
			if (mode_q) begin
				v = ((-72'(r_s8[2][j])) + (72'sd1 <<< (DOWN - 1))) >>> DOWN;
				e_c[3][j] = sat32(v);
			end else begin
				e_c[3][j] = '0;
			end
		end
		if (mode_q) begin
			e_c[3][3] = sat32(-72'(t_s8[2]));
		end else begin
			e_c[3][3] = 32'sd1 <<< FRAC_BITS;
		end
	end

	// payload: hold everything while adv is low
	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1
			for (int l = 0; l < 3; l++) begin
				q_s1[l] <= q_c[l];
				f_s1[l] <= f_c[l];
			end
			pos_s1[0] <= pos_x;
			pos_s1[1] <= pos_y;
			pos_s1[2] <= pos_z;
			// stage 2: seed the rotators
			for (int l = 0; l < 3; l++) begin
				x_s3[0][l]   <= CORDIC_X0;
				y_s3[0][l]   <= '0;
				z_s3[0][l]   <= zp_c[l][47:16];
				q_s3[0][l]   <= q_s1[l];
				pos_s3[0][l] <= pos_s1[l];
			end
			// one rotation step per stage
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				for (int l = 0; l < 3; l++) begin
					if (z_s3[i][l] >= 0) begin
						x_s3[i+1][l] <= x_s3[i][l] - (y_s3[i][l] >>> i);
						y_s3[i+1][l] <= y_s3[i][l] + (x_s3[i][l] >>> i);
						z_s3[i+1][l] <= z_s3[i][l] - ATAN_TAB[i];
					end else begin
						x_s3[i+1][l] <= x_s3[i][l] + (y_s3[i][l] >>> i);
						y_s3[i+1][l] <= y_s3[i][l] - (x_s3[i][l] >>> i);
						z_s3[i+1][l] <= z_s3[i][l] + ATAN_TAB[i];
					end
					q_s3[i+1][l]   <= q_s3[i][l];
					pos_s3[i+1][l] <= pos_s3[i][l];
				end
			end
			// stage 4: sines and cosines
			for (int l = 0; l < 3; l++) begin
				s_s4[l]   <= s_c[l];
				c_s4[l]   <= c_c[l];
				pos_s4[l] <= pos_s3[CORDIC_STEPS][l];
			end
			// stage 5: first product layer
			sxsy_s5 <= mul30(s_s4[0], s_s4[1]);
			cxsy_s5 <= mul30(c_s4[0], s_s4[1]);
			cxsz_s5 <= mul30(c_s4[0], s_s4[2]);
			cxcz_s5 <= mul30(c_s4[0], c_s4[2]);
			sxsz_s5 <= mul30(s_s4[0], s_s4[2]);
			sxcz_s5 <= mul30(s_s4[0], c_s4[2]);
			r00_s5  <= mul30(c_s4[1], c_s4[2]);
			r01_s5  <= mul30(c_s4[1], s_s4[2]);
			r02_s5  <= -s_s4[1];
			r12_s5  <= mul30(s_s4[0], c_s4[1]);
			r22_s5  <= mul30(c_s4[0], c_s4[1]);
			sz_s5   <= s_s4[2];
			cz_s5   <= c_s4[2];
			pos_s5  <= pos_s4;
			// stage 6: rotation matrix
			r_s6[0][0] <= r00_s5;
			r_s6[0][1] <= r01_s5;
			r_s6[0][2] <= r02_s5;
			r_s6[1][0] <= mul30(sxsy_s5, cz_s5) - cxsz_s5;
			r_s6[1][1] <= mul30(sxsy_s5, sz_s5) + cxcz_s5;
			r_s6[1][2] <= r12_s5;
			r_s6[2][0] <= mul30(cxsy_s5, cz_s5) + sxsz_s5;
			r_s6[2][1] <= mul30(cxsy_s5, sz_s5) - sxcz_s5;
			r_s6[2][2] <= r22_s5;
			pos_s6     <= pos_s5;
			// stage 7: R times position, term by term
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pr_s7[i][j] <= 65'(r_s6[i][j]) * 65'(pos_s6[j]);
				end
			end
			r_s7 <= r_s6;
			// stage 8: translation
			r_s8 <= r_s7;
			t_s8 <= t_c;
			// stage 9: final matrix
			e_s9 <= e_c;
		end
	end

	// row sequencer: drop one row per beat, row 0 first
	assign row_index = row_q;
	assign last_row  = (row_q == 2'd3);
	assign entry_c0  = e_s9[row_q][0];
	assign entry_c1  = e_s9[row_q][1];
	assign entry_c2  = e_s9[row_q][2];
	assign entry_c3  = e_s9[row_q][3];

endmodule

/* bench/tb_euler_view_projection_matrix_core.sv */
module tb_euler_view_projection_matrix_core;
	import vpm_pkg::*;

	localparam int STEPS = CORDIC_STEPS_DEF;
	localparam int FRAC  = FRAC_BITS_DEF;
	// Outside the register map; the block must drop a write to it.
	localparam logic [2:0] REG_SPARE = 3'd7;
	localparam int HOLD_CYCLES = 80;
	localparam logic MODE_VIEW = 1'b0;
	localparam logic MODE_PROJ = 1'b1;

	typedef logic signed [95:0] big_t;

	typedef struct {
		logic [1:0] row;
		word_t      c [4];
		logic       last;
	} row_beat_t;

	typedef struct {
		logic              mode;
		logic signed [17:0] ax, ay, az;
		word_t             px, py, pz;
		bit                pin_w;   // row 3 typed in: 0, 0, 0, 1.0
	} pose_row_t;

	logic clk, arst_n;
	logic in_valid, in_stall;
	logic signed [17:0] rot_x, rot_y, rot_z;
	word_t pos_x, pos_y, pos_z;
	logic out_valid, out_stall;
	logic [1:0] row_index;
	word_t entry_c0, entry_c1, entry_c2, entry_c3;
	logic last_row;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	euler_view_projection_matrix_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.row_index(row_index),
		.entry_c0(entry_c0), .entry_c1(entry_c1), .entry_c2(entry_c2), .entry_c3(entry_c3),
		.last_row(last_row),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the config registers
	logic  view_sel;
	word_t kx, ky, kz, koff;

	row_beat_t pending_rows [$];
	int errors = 0;
	int items_sent = 0;
	int rows_seen = 0;
	bit idle_on = 1;
	bit hold_req = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#4000000;
		$display("FAIL");
		$finish;
	end

	task automatic report(input string what, input int row, input longint got, input longint want);
		errors++;
		$display("mismatch %s row %0d: got %0d expected %0d", what, row, got, want);
	endtask

	// Round half up after dropping s fraction bits
	function automatic big_t rnd(input big_t v, input int s);
		return (v + (big_t'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic big_t clip(input big_t v);
		if (v > 96'sd2147483647) return 96'sd2147483647;
		if (v < -96'sd2147483648) return -96'sd2147483648;
		return v;
	endfunction

	function automatic big_t qmul(input big_t a, input big_t b);
		return rnd(a * b, TRIG_FRAC);
	endfunction

	// Sine and cosine of an angle in 1/256 degree, Q30
	task automatic angle_sincos(input logic signed [17:0] ang, output big_t s, output big_t c);
		longint r, q, f, x, y, z, nx;
		r = longint'(ang) % longint'(TURN_UNITS);
		if (r < 0) r += longint'(TURN_UNITS);
		q = r / longint'(QUARTER_UNITS);
		f = r - q * longint'(QUARTER_UNITS);
		z = (f * longint'(UNIT_TO_RAD) + 32768) >>> 16;
		x = longint'(CORDIC_X0);
		y = 0;
		for (int i = 0; i < STEPS && i < ATAN_DEPTH; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(ATAN_TAB[i]);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(ATAN_TAB[i]);
			end
			x = nx;
		end
		case (q)
			0: begin c = x; s = y; end
			1: begin c = -y; s = x; end
			2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	// Build the four row beats of one camera pose and queue them
	task automatic queue_matrix(input pose_row_t p);
		big_t sx, cx, sy, cy, sz, cz, sxsy, cxsy;
		big_t r [3][3];
		big_t t [3];
		big_t e [4][4];
		big_t pv [3];
		big_t k [3];
		row_beat_t b;
		angle_sincos(p.ax, sx, cx);
		angle_sincos(p.ay, sy, cy);
		angle_sincos(p.az, sz, cz);
		pv[0] = p.px; pv[1] = p.py; pv[2] = p.pz;
		sxsy = qmul(sx, sy);
		cxsy = qmul(cx, sy);
		r[0][0] = qmul(cy, cz);
		r[0][1] = qmul(cy, sz);
		r[0][2] = -sy;
		r[1][0] = qmul(sxsy, cz) - qmul(cx, sz);
		r[1][1] = qmul(sxsy, sz) + qmul(cx, cz);
		r[1][2] = qmul(sx, cy);
		r[2][0] = qmul(cxsy, cz) + qmul(sx, sz);
		r[2][1] = qmul(cxsy, sz) - qmul(sx, cz);
		r[2][2] = qmul(cx, cy);
		for (int i = 0; i < 3; i++)
			t[i] = clip(rnd(-(r[i][0] * pv[0] + r[i][1] * pv[1] + r[i][2] * pv[2]), TRIG_FRAC));
		if (view_sel == MODE_VIEW) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) e[i][j] = rnd(r[i][j], TRIG_FRAC - FRAC);
				e[i][3] = t[i];
			end
			e[3][0] = 0; e[3][1] = 0; e[3][2] = 0;
			e[3][3] = big_t'(1) <<< FRAC;
		end else begin
			k[0] = kx; k[1] = ky; k[2] = kz;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) e[i][j] = rnd(k[i] * r[i][j], TRIG_FRAC);
				e[i][3] = rnd(k[i] * t[i], FRAC);
			end
			e[2][3] = rnd(big_t'(kz) * t[2] + (big_t'(koff) <<< FRAC), FRAC);
			for (int j = 0; j < 3; j++) e[3][j] = rnd(-r[2][j], TRIG_FRAC - FRAC);
			e[3][3] = -t[2];
		end
		for (int i = 0; i < 4; i++) begin
			b.row = 2'(i);
			for (int j = 0; j < 4; j++) b.c[j] = word_t'(clip(e[i][j]));
			b.last = (i == 3);
			if (i == 3 && p.pin_w) begin
				// identity bottom row, typed in
				b.c[0] = 32'sd0; b.c[1] = 32'sd0; b.c[2] = 32'sd0; b.c[3] = 32'sd65536;
			end
			pending_rows.push_back(b);
		end
	endtask

	// Result side: check each row beat, then pick the next stall
	initial begin
		int stall_left;
		row_beat_t want;
		word_t got [4];
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				rows_seen++;
				if (pending_rows.size() == 0) begin
					errors++;
					$display("unexpected row beat, row %0d", row_index);
				end else begin
					want = pending_rows.pop_front();
					got[0] = entry_c0; got[1] = entry_c1; got[2] = entry_c2; got[3] = entry_c3;
					if (row_index !== want.row) report("row_index", want.row, row_index, want.row);
					for (int j = 0; j < 4; j++)
						if (got[j] !== want.c[j])
							report($sformatf("entry_c%0d", j), want.row, got[j], want.c[j]);
					if (last_row !== want.last) report("last_row", want.row, last_row, want.last);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
			end else if (hold_req) begin
				// long hold-off: let the pipe fill and push back on the input
				stall_left = HOLD_CYCLES;
				hold_req = 0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 5);
			end
			out_stall <= (stall_left > 0);
		end
	end

	// Offer one pose; hold it until the block takes the beat
	task automatic send_pose(input pose_row_t p);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		rot_x <= p.ax; rot_y <= p.ay; rot_z <= p.az;
		pos_x <= p.px; pos_y <= p.py; pos_z <= p.pz;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		queue_matrix(p);
		items_sent++;
	endtask

	// Drain the block, then write one register
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		in_valid <= 1'b0;
		while (pending_rows.size() != 0) @(posedge clk);
		repeat (STEPS + 12) @(posedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_OUTPUT_MODE:  view_sel = val[0];
			REG_PROJ_SCALE_X: kx = val;
			REG_PROJ_SCALE_Y: ky = val;
			REG_DEPTH_SCALE:  kz = val;
			REG_DEPTH_OFFSET: koff = val;
			default: ;
		endcase
	endtask

	function automatic word_t pick_pos();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return $urandom;
			default: return word_t'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
		endcase
	endfunction

	function automatic logic signed [17:0] pick_angle();
		if ($urandom_range(0, 3) == 0) return 18'($urandom_range(0, 262143));
		return 18'($signed($urandom_range(0, 2 * 92160)) - 92160);
	endfunction

	task automatic random_poses(input int n);
		pose_row_t p;
		for (int i = 0; i < n; i++) begin
			p.mode = view_sel;
			p.ax = pick_angle(); p.ay = pick_angle(); p.az = pick_angle();
			p.px = pick_pos(); p.py = pick_pos(); p.pz = pick_pos();
			p.pin_w = 0;
			send_pose(p);
		end
	endtask

	pose_row_t directed [] = '{
		// reset settings: projection mode, unit scales
		'{MODE_PROJ, 18'sd0, 18'sd0, 18'sd0, 32'sd0, 32'sd0, 32'sd0, 0},
		'{MODE_PROJ, 18'sd23040, 18'sd0, 18'sd0, 32'sd65536, 32'sd0, 32'sd0, 0},
		'{MODE_PROJ, 18'sd0, 18'sd46080, 18'sd0, 32'sd0, 32'sd65536, 32'sd0, 0},
		'{MODE_PROJ, 18'sd0, 18'sd0, 18'sd69120, 32'sd0, 32'sd0, 32'sd65536, 0},
		'{MODE_PROJ, 18'sd92160, -18'sd92160, 18'sd1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0},
		'{MODE_PROJ, 18'sd131071, -18'sd131072, -18'sd1, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0},
		'{MODE_PROJ, 18'sd11520, 18'sd11520, 18'sd11520, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 0},
		'{MODE_PROJ, -18'sd23040, 18'sd23039, 18'sd23041, 32'sd1, -32'sd1, 32'sd0, 0},
		// view mode: bottom row is always the identity row
		'{MODE_VIEW, 18'sd0, 18'sd0, 18'sd0, 32'sd0, 32'sd0, 32'sd0, 1},
		'{MODE_VIEW, 18'sd92160, 18'sd92160, 18'sd92160, 32'sd65536, -32'sd65536, 32'sd131072, 1},
		'{MODE_VIEW, -18'sd92160, 18'sd131071, -18'sd131072, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1},
		'{MODE_VIEW, 18'sd69120, 18'sd46080, 18'sd23040, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1},
		'{MODE_VIEW, 18'sd11520, -18'sd34560, 18'sd7680, 32'sd12345678, -32'sd987654, 32'sd42, 1},
		'{MODE_VIEW, -18'sd1, 18'sd1, 18'sd92159, -32'sd1, 32'sd1, 32'sd0, 1}
	};

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		rot_x = '0; rot_y = '0; rot_z = '0;
		pos_x = '0; pos_y = '0; pos_z = '0;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		view_sel = MODE_PROJ;
		kx = 32'sd65536; ky = 32'sd65536; kz = -32'sd65536; koff = -32'sd131072;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed poses; switch mode only when the row asks for it
		foreach (directed[i]) begin
			if (directed[i].mode != view_sel) write_reg(REG_OUTPUT_MODE, {31'd0, directed[i].mode});
			send_pose(directed[i]);
		end

		// View mode, random poses; hold off the result side early on
		hold_req = 1;
		random_poses(45);

		// Projection at the scale extremes
		write_reg(REG_OUTPUT_MODE, 32'd1);
		write_reg(REG_PROJ_SCALE_X, 32'h7FFFFFFF);
		write_reg(REG_PROJ_SCALE_Y, 32'h80000000);
		write_reg(REG_DEPTH_SCALE, 32'h7FFFFFFF);
		write_reg(REG_DEPTH_OFFSET, 32'h80000000);
		random_poses(35);

		// Opposite extremes, plus a write to a spare index that must be dropped
		write_reg(REG_PROJ_SCALE_X, 32'h80000000);
		write_reg(REG_PROJ_SCALE_Y, 32'h7FFFFFFF);
		write_reg(REG_DEPTH_SCALE, 32'h80000000);
		write_reg(REG_DEPTH_OFFSET, 32'h7FFFFFFF);
		write_reg(REG_SPARE, $urandom);
		random_poses(35);

		// Typical camera settings with random values, then view mode (bit 0 of the write is clear)
		write_reg(REG_PROJ_SCALE_X, $urandom_range(30000, 200000));
		write_reg(REG_PROJ_SCALE_Y, $urandom);
		write_reg(REG_DEPTH_SCALE, -$urandom_range(65536, 80000));
		write_reg(REG_DEPTH_OFFSET, $urandom);
		write_reg(REG_OUTPUT_MODE, 32'hFFFFFFFE);
		random_poses(35);

		// Back to projection, and run the tail at full rate
		write_reg(REG_OUTPUT_MODE, 32'd1);
		idle_on = 0;
		random_poses(40);
		in_valid <= 1'b0;

		while (pending_rows.size() != 0) @(posedge clk);
		repeat (STEPS + 20) @(posedge clk);
		$display("covered %0d poses, %0d row beats, view and projection modes", items_sent,
			rows_seen);
		$display("scale registers at both extremes, spare index write, input back-pressure");
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
